// File: design/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared widths, codes and defaults of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGES_DEF      = 65536;
	localparam int WORD_BITS_DEF  = 64;
	localparam int PAGE_SHIFT_DEF = 12;

	localparam int FUNC_W   = 2;
	localparam int CNT_W    = 17;
	localparam int ADDR_W   = 64;
	localparam int STATUS_W = 2;

	// Stream payloads: 2 + 17 + 64 and 64 + 2 + 17 bits, padded to 88
	localparam int IN_W  = 88;
	localparam int OUT_W = 88;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_TOTAL   = 1'd1;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC_ONE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC_RUN = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FREE_RUN  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_MEM  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD_ARG = 2'd2;

	localparam logic [CNT_W-1:0] PAGE_TOTAL_RST = 17'd65536;

endpackage

// File: design/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page frame allocator over a used-page bitmap held in one synchronous RAM.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   func, length, address
// m_axis    out  m_axis_tvalid/tready   result_address, status, free_total
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// Sequence: every bitmap word visited is read in ST_RD, then evaluated and
//   written back in ST_EVAL. A single allocate scans from the hint with wrap;
//   a run allocate scans from word 0, stepping bit by bit only through partly
//   used words, then walks the run again to mark it. A free skips the words
//   below the run start in ST_SEEK, then reads and rewrites each word in it.
// Reset: a clearing pass writes all ones into the MAP_WORDS words of the RAM
//   (1024 words at the defaults); no transaction is taken then.
// Stalls: a new transaction is taken while a result still waits on m_axis;
//   a finished result holds in DONE until the output register is free.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
	parameter int PAGES      = bpa_pkg::PAGES_DEF,
	parameter int WORD_BITS  = bpa_pkg::WORD_BITS_DEF,
	parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// func [1:0], length [18:2], address [82:19], zero pad
	input  logic [bpa_pkg::IN_W-1:0]      s_axis_tdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// result_address [63:0], status [65:64], free_total [82:66], zero pad
	output logic [bpa_pkg::OUT_W-1:0]     m_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bpa_pkg::*;

	localparam int MAP_WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int IW = $clog2(PAGES);
	localparam int PW = IW + 1;                 // page numbers up to PAGES + WORD_BITS
	localparam int BW = $clog2(WORD_BITS);      // bit index in a word
	localparam int OW = $clog2(WORD_BITS + 1);  // bit offset up to WORD_BITS
	localparam int XW = ((PW > CNT_W) ? PW : CNT_W) + 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
	localparam logic [PW-1:0] W_PW      = PW'(WORD_BITS);
	localparam logic [OW-1:0] W_OW      = OW'(WORD_BITS);
	localparam logic [BW-1:0] LAST_BIT  = BW'(WORD_BITS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_VAL1, ST_VAL2, ST_SEEK, ST_RD, ST_EVAL, ST_BIT, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_ONE, OP_SCAN, OP_MARK, OP_FREE
	} op_t;

	// Offset of page x inside the word whose bit 0 is page b, clipped to [0, W]
	function automatic logic [OW-1:0] clip_off(input logic [PW-1:0] x,
			input logic [PW-1:0] b);
		logic [PW-1:0] d;
		d = x - b;
		if (x <= b)
			return '0;
		if (d >= W_PW)
			return W_OW;
		return d[OW-1:0];
	endfunction

	// Bits below offset n set
	function automatic logic [WORD_BITS-1:0] thermo(input logic [OW-1:0] n);
		logic [WORD_BITS-1:0] m;
		for (int j = 0; j < WORD_BITS; j++)
			m[j] = (OW'(j) < n);
		return m;
	endfunction

	function automatic logic [BW-1:0] first_one(input logic [WORD_BITS-1:0] v);
		logic [BW-1:0] idx;
		idx = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--)
			if (v[j])
				idx = BW'(j);
		return idx;
	endfunction

	function automatic logic [OW-1:0] pop_count(input logic [WORD_BITS-1:0] v);
		logic [OW-1:0] c;
		c = '0;
		for (int j = 0; j < WORD_BITS; j++)
			c = c + OW'(v[j]);
		return c;
	endfunction

	// Configuration
	logic [ADDR_W-1:0] base_address_q;
	logic [CNT_W-1:0]  page_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= '0;
			page_total_q   <= PAGE_TOTAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_ADDRESS: base_address_q <= cfg_data;
				REG_PAGE_TOTAL:   page_total_q   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Bitmap RAM with registered read data
	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rd_data;
	logic                 mem_we;
	logic [WORD_BITS-1:0] mem_wd;
	logic [AW-1:0]        word_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[word_q] <= mem_wd;
		rd_data <= map_mem[word_q];
	end

	// Control and datapath registers
	state_t               state_q;
	op_t                  op_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    off_q;
	logic [PW-1:0]        tot_q;
	logic [PW-1:0]        start_q;
	logic                 phase_q;
	logic [PW-1:0]        base_q;
	logic [PW-1:0]        run_q;
	logic [PW-1:0]        rs_pg_q;
	logic [AW-1:0]        rs_word_q;
	logic [PW-1:0]        rs_base_q;
	logic [PW-1:0]        lo_q;
	logic [PW-1:0]        hi_q;
	logic [WORD_BITS-1:0] d_q;
	logic [BW-1:0]        bit_q;
	logic [PW-1:0]        res_pg_q;
	logic                 res_addr_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 hset_q;
	logic [PW-1:0]        free_cnt_q;
	logic [PW-1:0]        hint_pg_q;
	logic [AW-1:0]        hint_word_q;
	logic [PW-1:0]        hint_base_q;
	logic [BW-1:0]        hint_bit_q;
	logic [OUT_W-1:0]     m_data_q;
	logic                 m_valid_q;

	// Input fields
	logic [FUNC_W-1:0] in_func;
	logic [CNT_W-1:0]  in_cnt;
	logic [ADDR_W-1:0] in_addr;
	logic [PW-1:0]     tot_c;
	logic              hint_ok;

	assign in_func = s_axis_tdata[1:0];
	assign in_cnt  = s_axis_tdata[18:2];
	assign in_addr = s_axis_tdata[82:19];
	assign tot_c   = (XW'(page_total_q) > XW'(PAGES)) ? PW'(PAGES) : PW'(page_total_q);
	// Start a single search at the hint only while it lies inside the managed pages
	assign hint_ok = (in_func == FUNC_ALLOC_ONE) && (hint_pg_q < tot_c);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tvalid = m_valid_q;

	// Word evaluation
	logic [PW-1:0]        nb;
	logic [OW-1:0]        lo_off;
	logic [OW-1:0]        hi_off;
	logic [WORD_BITS-1:0] vmask;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] freed_bits;
	logic [BW-1:0]        fb;
	logic [BW-1:0]        ffb;
	logic [OW-1:0]        lim;
	logic [PW-1:0]        run_w;
	logic [PW-1:0]        run_b;
	logic [ADDR_W-1:0]    first;
	logic                 out_free;

	assign nb = base_q + W_PW;

	always_comb begin
		case (op_q)
			OP_ONE: begin
				lo_off = phase_q ? '0 : clip_off(start_q, base_q);
				hi_off = phase_q ? clip_off(start_q, base_q) : clip_off(tot_q, base_q);
			end
			default: begin
				lo_off = clip_off(lo_q, base_q);
				hi_off = clip_off(hi_q, base_q);
			end
		endcase
	end

	assign vmask      = thermo(hi_off) & ~thermo(lo_off);
	assign free_bits  = ~rd_data & vmask;
	assign freed_bits = rd_data & vmask;
	assign fb         = first_one(free_bits);
	assign ffb        = first_one(freed_bits);
	assign lim        = clip_off(tot_q, base_q);
	assign run_w      = run_q + W_PW;
	assign run_b      = run_q + PW'(1);
	assign first      = off_q >> PAGE_SHIFT;
	assign out_free   = !m_valid_q || m_axis_tready;

	always_comb begin
		mem_we = 1'b0;
		mem_wd = rd_data;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wd = '1;
			end
			ST_EVAL: begin
				case (op_q)
					OP_ONE: begin
						mem_we = |free_bits;
						mem_wd = rd_data | (WORD_BITS'(1) << fb);
					end
					OP_MARK: begin
						mem_we = 1'b1;
						mem_wd = rd_data | vmask;
					end
					OP_FREE: begin
						mem_we = 1'b1;
						mem_wd = rd_data & ~vmask;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			op_q        <= OP_ONE;
			word_q      <= '0;
			free_cnt_q  <= '0;
			hint_pg_q   <= '0;
			hint_word_q <= '0;
			hint_base_q <= '0;
			hint_bit_q  <= '0;
			m_valid_q   <= 1'b0;
			hset_q      <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			// Drop the output once taken, unless DONE reloads it in this cycle
			if (m_valid_q && m_axis_tready && state_q != ST_DONE)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					// Fill the bitmap with ones, one word a cycle
					if (word_q == LAST_WORD) begin
						word_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						word_q <= word_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cnt_q      <= in_cnt;
						addr_q     <= in_addr;
						tot_q      <= tot_c;
						res_addr_q <= 1'b0;
						hset_q     <= 1'b0;
						phase_q    <= 1'b0;
						run_q      <= '0;
						word_q     <= hint_ok ? hint_word_q : '0;
						base_q     <= hint_ok ? hint_base_q : '0;
						case (in_func)
							FUNC_ALLOC_ONE: begin
								op_q     <= OP_ONE;
								status_q <= STAT_NO_MEM;
								start_q  <= hint_ok ? hint_pg_q : '0;
								state_q  <= (tot_c == '0) ? ST_DONE : ST_RD;
							end
							FUNC_ALLOC_RUN: begin
								op_q     <= OP_SCAN;
								status_q <= (in_cnt == '0) ? STAT_BAD_ARG : STAT_NO_MEM;
								if (in_cnt == '0 || XW'(in_cnt) > XW'(tot_c))
									state_q <= ST_DONE;
								else
									state_q <= ST_RD;
							end
							FUNC_FREE_RUN: begin
								op_q     <= OP_FREE;
								status_q <= STAT_NO_MEM;
								state_q  <= ST_VAL1;
							end
							default: begin
								status_q <= STAT_BAD_ARG;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_VAL1: begin
					off_q <= addr_q - base_address_q;
					if (addr_q == '0 || cnt_q == '0 || addr_q < base_address_q ||
							addr_q[PAGE_SHIFT-1:0] != '0) begin
						status_q <= STAT_BAD_ARG;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_VAL2;
					end
				end
				ST_VAL2: begin
					if (first[ADDR_W-1:PW] == '0 && first[PW-1:0] < tot_q &&
							XW'(cnt_q) <= XW'(tot_q - first[PW-1:0])) begin
						lo_q    <= first[PW-1:0];
						hi_q    <= first[PW-1:0] + PW'(cnt_q);
						state_q <= ST_SEEK;
					end else begin
						status_q <= STAT_BAD_ARG;
						state_q  <= ST_DONE;
					end
				end
				ST_SEEK: begin
					// Skip words wholly below the run
					if (nb <= lo_q) begin
						word_q <= word_q + AW'(1);
						base_q <= nb;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_EVAL;
				ST_EVAL: begin
					case (op_q)
						OP_ONE: begin
							if (|free_bits) begin
								if (free_cnt_q != '0)
									free_cnt_q <= free_cnt_q - PW'(1);
								res_pg_q   <= base_q + PW'(fb);
								res_addr_q <= 1'b1;
								status_q   <= STAT_OK;
								state_q    <= ST_DONE;
								// Advance the hint just past the page, wrap at the total
								if (XW'(base_q + PW'(fb)) + XW'(1) >= XW'(tot_q)) begin
									hint_pg_q   <= '0;
									hint_word_q <= '0;
									hint_base_q <= '0;
									hint_bit_q  <= '0;
								end else if (fb == LAST_BIT) begin
									hint_pg_q   <= nb;
									hint_word_q <= word_q + AW'(1);
									hint_base_q <= nb;
									hint_bit_q  <= '0;
								end else begin
									hint_pg_q   <= base_q + PW'(fb) + PW'(1);
									hint_word_q <= word_q;
									hint_base_q <= base_q;
									hint_bit_q  <= fb + BW'(1);
								end
							end else if (!phase_q) begin
								if (nb >= tot_q) begin
									if (start_q == '0) begin
										state_q <= ST_DONE;
									end else begin
										phase_q <= 1'b1;
										word_q  <= '0;
										base_q  <= '0;
										state_q <= ST_RD;
									end
								end else begin
									word_q  <= word_q + AW'(1);
									base_q  <= nb;
									state_q <= ST_RD;
								end
							end else begin
								if (nb >= start_q) begin
									state_q <= ST_DONE;
								end else begin
									word_q  <= word_q + AW'(1);
									base_q  <= nb;
									state_q <= ST_RD;
								end
							end
						end
						OP_SCAN: begin
							if (lim == W_OW && rd_data == '0) begin
								// Whole word free: extend the run
								if (XW'(run_w) >= XW'(cnt_q)) begin
									op_q   <= OP_MARK;
									lo_q   <= (run_q == '0) ? base_q : rs_pg_q;
									hi_q   <= ((run_q == '0) ? base_q : rs_pg_q) + PW'(cnt_q);
									word_q <= (run_q == '0) ? word_q : rs_word_q;
									base_q <= (run_q == '0) ? base_q : rs_base_q;
									state_q <= ST_RD;
								end else begin
									run_q <= run_w;
									if (run_q == '0) begin
										rs_pg_q   <= base_q;
										rs_word_q <= word_q;
										rs_base_q <= base_q;
									end
									if (nb >= tot_q) begin
										state_q <= ST_DONE;
									end else begin
										word_q  <= word_q + AW'(1);
										base_q  <= nb;
										state_q <= ST_RD;
									end
								end
							end else if (lim == W_OW && (&rd_data)) begin
								run_q <= '0;
								if (nb >= tot_q) begin
									state_q <= ST_DONE;
								end else begin
									word_q  <= word_q + AW'(1);
									base_q  <= nb;
									state_q <= ST_RD;
								end
							end else begin
								d_q     <= rd_data;
								bit_q   <= '0;
								state_q <= ST_BIT;
							end
						end
						OP_MARK: begin
							if (nb >= hi_q) begin
								free_cnt_q <= (XW'(free_cnt_q) >= XW'(cnt_q)) ?
									free_cnt_q - PW'(cnt_q) : '0;
								res_pg_q   <= lo_q;
								res_addr_q <= 1'b1;
								status_q   <= STAT_OK;
								state_q    <= ST_DONE;
							end else begin
								word_q  <= word_q + AW'(1);
								base_q  <= nb;
								state_q <= ST_RD;
							end
						end
						default: begin
							// Free: count pages that really change, lower the hint once
							free_cnt_q <= free_cnt_q + PW'(pop_count(freed_bits));
							if ((|freed_bits) && !hset_q) begin
								hset_q <= 1'b1;
								if (base_q + PW'(ffb) < hint_pg_q) begin
									hint_pg_q   <= base_q + PW'(ffb);
									hint_word_q <= word_q;
									hint_base_q <= base_q;
									hint_bit_q  <= ffb;
								end
							end
							if (nb >= hi_q) begin
								status_q <= STAT_OK;
								state_q  <= ST_DONE;
							end else begin
								word_q  <= word_q + AW'(1);
								base_q  <= nb;
								state_q <= ST_RD;
							end
						end
					endcase
				end
				ST_BIT: begin
					// Step through a partly used word one page a cycle
					if (OW'(bit_q) >= lim) begin
						state_q <= ST_DONE;
					end else if (!d_q[bit_q] && XW'(run_b) == XW'(cnt_q)) begin
						op_q    <= OP_MARK;
						lo_q    <= (run_q == '0) ? base_q + PW'(bit_q) : rs_pg_q;
						hi_q    <= ((run_q == '0) ? base_q + PW'(bit_q) : rs_pg_q) + PW'(cnt_q);
						word_q  <= (run_q == '0) ? word_q : rs_word_q;
						base_q  <= (run_q == '0) ? base_q : rs_base_q;
						state_q <= ST_RD;
					end else begin
						if (d_q[bit_q]) begin
							run_q <= '0;
						end else begin
							run_q <= run_b;
							if (run_q == '0) begin
								rs_pg_q   <= base_q + PW'(bit_q);
								rs_word_q <= word_q;
								rs_base_q <= base_q;
							end
						end
						if (bit_q == LAST_BIT) begin
							if (nb >= tot_q) begin
								state_q <= ST_DONE;
							end else begin
								word_q  <= word_q + AW'(1);
								base_q  <= nb;
								state_q <= ST_RD;
							end
						end else begin
							bit_q <= bit_q + BW'(1);
						end
					end
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {5'd0, CNT_W'(free_cnt_q), status_q,
							res_addr_q ? base_address_q + (ADDR_W'(res_pg_q) << PAGE_SHIFT)
								: ADDR_W'(0)};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_free_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= PW'(PAGES))
		else $error("free page count above capacity");

	a_hint_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		hint_pg_q == hint_base_q + PW'(hint_bit_q))
		else $error("hint page and word position disagree");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mem_we)
		else $error("bitmap written while idle");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second transaction taken while busy");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> m_axis_tvalid)
		else $error("finished result not presented");
`endif

endmodule
